// File: hdl/cms_pkg.sv
package cms_pkg;

  localparam int unsigned SEQ_MAX = 5;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  localparam logic [7:0] PAYLOAD_MARKER = 8'hFF;
  localparam logic [15:0] EXT1_BASE = 16'd13;
  localparam logic [15:0] EXT2_BASE = 16'd269;
  localparam logic [3:0] NIB_EXT1 = 4'd13;
  localparam logic [3:0] NIB_EXT2 = 4'd14;

  typedef enum logic [2:0] {
    REQ_HEADER    = 3'd0,
    REQ_TOKEN     = 3'd1,
    REQ_OPT_START = 3'd2,
    REQ_OPT_BYTE  = 3'd3,
    REQ_PAY_START = 3'd4,
    REQ_PAY_BYTE  = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_BODY    = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_OPT_DECR   = 2'd1;
  localparam logic [1:0] ST_OPT_AFTPAY = 2'd2;

  // one request's worth of output bytes
  typedef struct packed {
    logic [SEQ_MAX-1:0][7:0] seq;
    logic [2:0]              cnt;
    logic [1:0]              status;
    logic                    eom;
  } cmd_t;

  typedef struct packed {
    logic [3:0]      nib;
    logic [1:0]      cnt;
    logic [1:0][7:0] b;    // b[0] goes out first
  } ext_t;

  function automatic ext_t encode_ext(input logic [15:0] v);
    ext_t        e;
    logic [15:0] d;
    e = '0;
    if (v < EXT1_BASE) begin
      e.nib = v[3:0];
    end else if (v < EXT2_BASE) begin
      d = v - EXT1_BASE;
      e.nib = NIB_EXT1;
      e.cnt = 2'd1;
      e.b[0] = d[7:0];
    end else begin
      d = v - EXT2_BASE;
      e.nib = NIB_EXT2;
      e.cnt = 2'd2;
      e.b[0] = d[15:8];
      e.b[1] = d[7:0];
    end
    return e;
  endfunction

endpackage

// File: hdl/cms_front.sv
module cms_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic [2:0]       req_type,
  input  logic [1:0]       version,
  input  logic [1:0]       msg_type,
  input  logic [3:0]       token_length,
  input  logic [2:0]       code_class,
  input  logic [4:0]       code_detail,
  input  logic [15:0]      message_id,
  input  logic [15:0]      option_number,
  input  logic [15:0]      value_length,
  input  logic [7:0]       data_byte,
  input  logic             end_of_message,
  output logic             push,
  output cms_pkg::cmd_t    cmd
);
  import cms_pkg::*;

  logic [15:0] prev_opt_r, prev_opt_nxt;
  phase_t      phase_r, phase_nxt;
  ext_t        dext, lext;
  logic        decr;
  logic [15:0] delta;
  logic [3:0][7:0] ext_seq;

  assign decr  = option_number < prev_opt_r;
  assign delta = decr ? 16'd0 : option_number - prev_opt_r;
  assign dext  = encode_ext(delta);
  assign lext  = encode_ext(value_length);

  // delta extension first, then length extension
  always_comb begin
    ext_seq = '0;
    case (dext.cnt)
      2'd0: begin
        ext_seq[0] = lext.b[0];
        ext_seq[1] = lext.b[1];
      end
      2'd1: begin
        ext_seq[0] = dext.b[0];
        ext_seq[1] = lext.b[0];
        ext_seq[2] = lext.b[1];
      end
      default: begin
        ext_seq[0] = dext.b[0];
        ext_seq[1] = dext.b[1];
        ext_seq[2] = lext.b[0];
        ext_seq[3] = lext.b[1];
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.eom = end_of_message;
    prev_opt_nxt = prev_opt_r;
    phase_nxt = phase_r;
    push = 1'b0;
    case (req_type)
      REQ_HEADER: begin
        push = acc;
        cmd.seq[0] = {version, msg_type, token_length};
        cmd.seq[1] = {code_class, code_detail};
        cmd.seq[2] = message_id[15:8];
        cmd.seq[3] = message_id[7:0];
        cmd.cnt = 3'd4;
        prev_opt_nxt = '0;
        phase_nxt = PH_BODY;
      end
      REQ_OPT_START: begin
        push = acc;
        cmd.seq[0] = {dext.nib, lext.nib};
        cmd.seq[1] = ext_seq[0];
        cmd.seq[2] = ext_seq[1];
        cmd.seq[3] = ext_seq[2];
        cmd.seq[4] = ext_seq[3];
        cmd.cnt = 3'd1 + {1'b0, dext.cnt} + {1'b0, lext.cnt};
        if (decr) begin
          cmd.status = ST_OPT_DECR;
        end else begin
          prev_opt_nxt = option_number;
        end
        if (phase_r == PH_PAYLOAD) begin
          cmd.status = ST_OPT_AFTPAY;
        end
        if (phase_r == PH_IDLE) begin
          phase_nxt = PH_BODY;
        end
      end
      REQ_PAY_START: begin
        push = acc;
        cmd.seq[0] = PAYLOAD_MARKER;
        cmd.cnt = 3'd1;
        phase_nxt = PH_PAYLOAD;
      end
      REQ_TOKEN, REQ_OPT_BYTE, REQ_PAY_BYTE: begin
        push = acc;
        cmd.seq[0] = data_byte;
        cmd.cnt = 3'd1;
        if (phase_r == PH_IDLE) begin
          phase_nxt = PH_BODY;
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
    if (end_of_message) begin
      phase_nxt = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_opt_r <= '0;
      phase_r <= PH_IDLE;
    end else if (push) begin
      prev_opt_r <= prev_opt_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

// File: hdl/cms_queue.sv
module cms_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cms_pkg::cmd_t wr_cmd,
  input  logic          pop,
  output cms_pkg::cmd_t rd_cmd,
  output logic          full,
  output logic          empty
);
  import cms_pkg::*;

  cmd_t               mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]    cnt_r, cnt_nxt;

  assign full   = cnt_r == (QPTR_W+1)'(QDEPTH);
  assign empty  = cnt_r == '0;
  assign rd_cmd = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + (QPTR_W)'(push);
    rd_ptr_nxt = rd_ptr_r + (QPTR_W)'(pop);
    cnt_nxt = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hdl/cms_back.sv
module cms_back (
  input  logic          clk,
  input  logic          rst_n,
  input  cms_pkg::cmd_t cmd,
  input  logic          empty,
  output logic          pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,
  output logic          out_tlast,
  output logic [2:0]    out_tuser
);
  import cms_pkg::*;

  logic [2:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic [1:0] status_r;
  logic       mend_r;
  logic       load, fire, is_last;
  logic [7:0] sel_byte;

  assign load    = !vld_r || out_tready;
  assign fire    = load && !empty;
  assign is_last = idx_r == (cmd.cnt - 3'd1);
  assign pop     = fire && is_last;

  always_comb begin
    case (idx_r)
      3'd0: sel_byte = cmd.seq[0];
      3'd1: sel_byte = cmd.seq[1];
      3'd2: sel_byte = cmd.seq[2];
      3'd3: sel_byte = cmd.seq[3];
      3'd4: sel_byte = cmd.seq[4];
      default: sel_byte = cmd.seq[0];
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = !empty;
    end
    if (fire) begin
      idx_nxt = is_last ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      byte_r <= sel_byte;
      last_r <= is_last;
      status_r <= cmd.status;
      mend_r <= is_last && cmd.eom;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = byte_r;
  assign out_tlast  = last_r;
  assign out_tuser  = {mend_r, status_r};

endmodule

// File: hdl/coap_message_serializer.sv
// Message serializer for the constrained application protocol (RFC 7252).
// Input stream: one request per piece of a message; in_tuser carries the
// request kind (header, token byte, option start, option byte, payload start,
// payload byte), in_tlast marks the end of the whole message. Kinds 6 and 7
// are taken and dropped without output.
// Output stream: one serialized byte per beat. out_tlast marks the last byte
// produced by a request; out_tuser carries the status (option number went
// down, option after payload) and the message end flag.
// Throughput: one byte per cycle on the output while the receiver is ready.
// Single-byte requests are taken every cycle while the queue has room;
// a header yields 4 output bytes and an option start 1 to 5, all sent by
// the byte-serial output stage. A 4-entry request queue sits between
// classifier and output stage, so the input keeps taking requests while
// longer ones drain. Requests pass the queue, then the output register.
// Reset empties the queue and clears tvalid, option number and message phase.
// If the receiver stalls, the output byte holds and the queue fills; in_tready
// drops only when it is full or while in reset.
module coap_message_serializer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] version, [3:2] msg_type, [7:4] token_length, [10:8] code_class,
  // [15:11] code_detail, [31:16] message_id, [47:32] option_number,
  // [63:48] value_length, [71:64] data_byte
  input  logic [71:0] in_tdata,
  input  logic [2:0]  in_tuser,    // [2:0] req_type
  input  logic        in_tlast,    // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] out_byte
  output logic        out_tlast,   // last_of_run
  output logic [2:0]  out_tuser    // [1:0] status, [2] message_end
);
  import cms_pkg::*;

  logic push, pop, full, empty, acc;
  cmd_t wr_cmd, rd_cmd;

  assign in_tready = rst_n && !full;
  assign acc = in_tvalid && in_tready;

  cms_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc            (acc),
    .req_type       (in_tuser),
    .version        (in_tdata[1:0]),
    .msg_type       (in_tdata[3:2]),
    .token_length   (in_tdata[7:4]),
    .code_class     (in_tdata[10:8]),
    .code_detail    (in_tdata[15:11]),
    .message_id     (in_tdata[31:16]),
    .option_number  (in_tdata[47:32]),
    .value_length   (in_tdata[63:48]),
    .data_byte      (in_tdata[71:64]),
    .end_of_message (in_tlast),
    .push           (push),
    .cmd            (wr_cmd)
  );

  cms_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .rd_cmd (rd_cmd),
    .full   (full),
    .empty  (empty)
  );

  cms_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (rd_cmd),
    .empty      (empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// File: hdl/cms_checker.sv
module cms_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic [2:0] out_tuser
);

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("output beat changed under stall");

  // message end only on the last byte of a request
  a_mend_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tlast)
    else $error("message end without last of run");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[1:0] != 2'd3)
    else $error("invalid status code");

  // status is the same across all bytes of one request
  a_status_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      !out_tvalid || out_tuser[1:0] == $past(out_tuser[1:0]))
    else $error("status changed within a run");

endmodule

bind coap_message_serializer cms_checker u_cms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
